>>> rtl/core/rtdt_pkg.sv
// ----------------------------------------------------------------------------
// rtdt_pkg
// Shared types and constants for the range target detect and track block.
// ----------------------------------------------------------------------------
package rtdt_pkg;

	localparam int WIN_DEPTH   = 8;
	localparam int WIN_LOG2    = $clog2(WIN_DEPTH);
	localparam int SUM_W       = $clog2(WIN_DEPTH * 1024);
	localparam int SETTLE_MAX  = 2 * WIN_DEPTH;
	localparam int SETTLE_W    = $clog2(SETTLE_MAX + 1);

	localparam int RANGE_W     = 11;
	localparam int DIST_W      = 10;
	localparam int CNT_W       = 8;
	localparam int MISS_W      = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 10;

	localparam logic [DIST_W-1:0] BASELINE_RST = 10'd1000;
	localparam logic [DIST_W-1:0] DROP_RST     = 10'd30;
	localparam logic [DIST_W-1:0] CLOSE_RST    = 10'd15;
	localparam logic [CNT_W-1:0]  DETECT_RST   = 8'd6;
	localparam logic [MISS_W-1:0] LOST_RST     = 4'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASELINE = 3'd0,
		CFG_DROP     = 3'd1,
		CFG_CLOSE    = 3'd2,
		CFG_DETECT   = 3'd3,
		CFG_LOST     = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STEER_ROTATE  = 2'd0,
		STEER_FORWARD = 2'd1,
		STEER_LEFT    = 2'd2,
		STEER_RIGHT   = 2'd3
	} steer_t;

endpackage

>>> rtl/core/range_target_detect_track.sv
// ----------------------------------------------------------------------------
// range_target_detect_track
// Averages left/right range readings into a ring window held in a RAM and
// runs a search/chase machine on each sample to detect and follow a target.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  left_range, right_range, warm_done
// out      output     out_valid / out_stall steer, chasing, hit_count,
//                                           window_mean, window_full
// cfg      input      cfg_we               cfg_index, cfg_data
//
// One transfer per cycle sustained while the output is not stalled. The first
// stage reads the old window entry from the RAM (registered read); the second
// updates sum, counters, machine and result and writes the entry back. Reset
// clears all control state; window entries are not reset, and the old entry
// counts as zero in the sum until the window has wrapped once. An output stall
// holds the result register and any sample in flight, which stalls the input.
// ----------------------------------------------------------------------------
module range_target_detect_track
	import rtdt_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [RANGE_W-1:0]   left_range,
	input  logic signed [RANGE_W-1:0]   right_range,
	input  logic                        warm_done,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  steer,
	output logic                        chasing,
	output logic [CNT_W-1:0]            hit_count,
	output logic [DIST_W-1:0]           window_mean,
	output logic                        window_full
);

	logic [DIST_W-1:0]   baseline_q, drop_q, close_q;
	logic [CNT_W-1:0]    detect_need_q;
	logic [MISS_W-1:0]   lost_need_q;

	logic [DIST_W-1:0]   win_mem [WIN_DEPTH];

	logic [WIN_LOG2-1:0] slot_q;
	logic [SUM_W-1:0]    sum_q;
	logic                filled_q, warm_q, chase_q;
	logic [SETTLE_W-1:0] settle_q;
	logic [CNT_W-1:0]    det_q;
	logic [MISS_W-1:0]   miss_q;

	logic                       s1_valid_q;
	logic [WIN_LOG2-1:0]        slot_s1;
	logic [DIST_W-1:0]          sample_s1, old_s1;
	logic signed [RANGE_W-1:0]  left_s1, right_s1;
	logic                       warm_s1;

	logic                out_valid_q;
	logic [1:0]          steer_q;
	logic                chasing_q, full_q;
	logic [CNT_W-1:0]    hit_q;
	logic [DIST_W-1:0]   mean_q;

	logic                in_xfer, adv;
	logic                l_pos, r_pos;
	logic [DIST_W-1:0]   l_val, r_val, sample_in;
	logic [DIST_W:0]     pair_sum;

	logic                warm_eff, filled_nx, chase_nx, hit;
	logic [SUM_W-1:0]    sum_nx;
	logic [DIST_W-1:0]   mean_nx;
	logic signed [DIST_W+1:0] mean_diff;
	logic [SETTLE_W-1:0] settle_nx;
	logic [CNT_W-1:0]    det_nx, det_base, det_hit;
	logic [MISS_W-1:0]   miss_nx, miss_base, miss_tmp;
	logic [1:0]          steer_nx;
	logic                both_pos;
	logic signed [RANGE_W:0] l_ext, r_ext, c_ext;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = s1_valid_q && !adv;
	assign in_xfer  = in_valid && !in_stall;

	// input sample: substitute baseline, average
	assign l_pos     = !left_range[RANGE_W-1] && (left_range != '0);
	assign r_pos     = !right_range[RANGE_W-1] && (right_range != '0);
	assign l_val     = l_pos ? left_range[DIST_W-1:0] : baseline_q;
	assign r_val     = r_pos ? right_range[DIST_W-1:0] : baseline_q;
	assign pair_sum  = {1'b0, l_val} + {1'b0, r_val};
	assign sample_in = pair_sum[DIST_W:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q    <= BASELINE_RST;
			drop_q        <= DROP_RST;
			close_q       <= CLOSE_RST;
			detect_need_q <= DETECT_RST;
			lost_need_q   <= LOST_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BASELINE: baseline_q    <= cfg_data;
				CFG_DROP:     drop_q        <= cfg_data;
				CFG_CLOSE:    close_q       <= cfg_data;
				CFG_DETECT:   detect_need_q <= cfg_data[CNT_W-1:0];
				CFG_LOST:     lost_need_q   <= cfg_data[MISS_W-1:0];
				default: ;
			endcase
		end
	end

	// window RAM: read on input transfer, write back when the sample retires
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			old_s1 <= win_mem[slot_q];
		end
		if (s1_valid_q && adv) begin
			win_mem[slot_s1] <= sample_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			slot_s1   <= slot_q;
			sample_s1 <= sample_in;
			left_s1   <= left_range;
			right_s1  <= right_range;
			warm_s1   <= warm_done;
		end
	end

	// update stage
	always_comb begin
		warm_eff  = warm_q || warm_s1;
		det_base  = warm_q ? det_q : (warm_s1 ? '0 : det_q);
		miss_base = warm_q ? miss_q : (warm_s1 ? '0 : miss_q);
		sum_nx    = sum_q - (filled_q ? {{(SUM_W-DIST_W){1'b0}}, old_s1} : '0)
			+ {{(SUM_W-DIST_W){1'b0}}, sample_s1};
		mean_nx   = sum_nx[WIN_LOG2 +: DIST_W];
		filled_nx = filled_q || (slot_s1 == WIN_LOG2'(WIN_DEPTH - 1));
		mean_diff = $signed({2'b00, mean_nx}) - $signed({2'b00, sample_s1});
		hit       = (sample_s1 < close_q) ||
			(!mean_diff[DIST_W+1] && (mean_diff[DIST_W:0] > {1'b0, drop_q}));

		both_pos = !left_s1[RANGE_W-1] && (left_s1 != '0) &&
			!right_s1[RANGE_W-1] && (right_s1 != '0);
		l_ext    = {left_s1[RANGE_W-1], left_s1};
		r_ext    = {right_s1[RANGE_W-1], right_s1};
		c_ext    = $signed({2'b00, close_q});

		settle_nx = settle_q;
		det_nx    = det_base;
		miss_nx   = miss_base;
		chase_nx  = chase_q;
		steer_nx  = STEER_ROTATE;
		det_hit   = det_base;
		miss_tmp  = miss_base;

		if (!chase_q) begin
			if (warm_eff && filled_nx) begin
				if (settle_q < SETTLE_W'(SETTLE_MAX)) begin
					settle_nx = settle_q + 1'b1;
				end else begin
					if (hit) begin
						det_hit  = (det_base != '1) ? det_base + 1'b1 : det_base;
						miss_tmp = '0;
					end else if (det_base != '0) begin
						det_hit = det_base - 1'b1;
					end
					det_nx  = det_hit;
					miss_nx = miss_tmp;
					if (det_hit >= detect_need_q) begin
						chase_nx = 1'b1;
						det_nx   = '0;
						miss_nx  = '0;
					end
				end
			end
		end else begin
			if (both_pos && (l_ext < r_ext - c_ext)) begin
				steer_nx = STEER_LEFT;
			end else if (both_pos && (r_ext < l_ext - c_ext)) begin
				steer_nx = STEER_RIGHT;
			end else begin
				steer_nx = STEER_FORWARD;
			end
			if (warm_eff) begin
				if (!hit) begin
					miss_tmp = (miss_base != '1) ? miss_base + 1'b1 : miss_base;
				end else begin
					miss_tmp = '0;
				end
			end
			miss_nx = miss_tmp;
			if (miss_tmp >= lost_need_q) begin
				chase_nx = 1'b0;
				miss_nx  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			sum_q       <= '0;
			filled_q    <= 1'b0;
			warm_q      <= 1'b0;
			chase_q     <= 1'b0;
			settle_q    <= '0;
			det_q       <= '0;
			miss_q      <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				slot_q <= (slot_q == WIN_LOG2'(WIN_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			end
			if (adv) begin
				s1_valid_q  <= in_xfer;
				out_valid_q <= s1_valid_q;
			end else if (in_xfer) begin
				s1_valid_q <= 1'b1;
			end
			if (s1_valid_q && adv) begin
				sum_q    <= sum_nx;
				filled_q <= filled_nx;
				warm_q   <= warm_eff;
				chase_q  <= chase_nx;
				settle_q <= settle_nx;
				det_q    <= det_nx;
				miss_q   <= miss_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && adv) begin
			steer_q   <= steer_nx;
			chasing_q <= chase_nx;
			hit_q     <= det_nx;
			mean_q    <= mean_nx;
			full_q    <= filled_nx;
		end
	end

	assign out_valid   = out_valid_q;
	assign steer       = steer_q;
	assign chasing     = chasing_q;
	assign hit_count   = hit_q;
	assign window_mean = mean_q;
	assign window_full = full_q;

	a_chase_warm: assert property (@(posedge clk) disable iff (!arst_n)
		chase_q |-> (warm_q && filled_q))
		else $error("chasing without warm-up and full window");

	a_settle_max: assert property (@(posedge clk) disable iff (!arst_n)
		settle_q <= SETTLE_W'(SETTLE_MAX))
		else $error("settle counter past limit");

	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> (slot_q == ((slot_s1 == WIN_LOG2'(WIN_DEPTH - 1)) ?
			WIN_LOG2'(0) : slot_s1 + 1'b1)))
		else $error("read slot out of step with write slot");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid_q))
		else $error("input stalled with free pipeline");

endmodule
